@@ sv/mm4_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types, constants and the output saturation function for the 4x4
// fixed-point matrix multiply unit.
// ----------------------------------------------------------------------------
package mm4_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIM       = 4;
  localparam int IDX_W     = $clog2(DIM);
  localparam int ELEM_W    = 32;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int ACC_W     = PROD_W + IDX_W;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef elem_t [DIM-1:0]          row_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [IDX_W-1:0]         idx_t;

  // one queued transaction: a row of A, the matching row of B, its row index
  typedef struct packed {
    row_t a;
    row_t b;
    idx_t row;
  } item_t;

  localparam idx_t LAST_IDX = idx_t'(DIM - 1);

  // floor(s / 2^FRAC_BITS), clamped to the signed element range
  function automatic elem_t sat_shift(input acc_t s);
    acc_t  q;
    elem_t r;
    q = s >>> FRAC_BITS;
    if (!q[ACC_W-1] && (|q[ACC_W-2:ELEM_W-1])) begin
      r = {1'b0, {(ELEM_W-1){1'b1}}};
    end else if (q[ACC_W-1] && !(&q[ACC_W-2:ELEM_W-1])) begin
      r = {1'b1, {(ELEM_W-1){1'b0}}};
    end else begin
      r = q[ELEM_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ sv/mm4_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_front
// Accepts input rows, tags each with its row index within the matrix pair
// and holds them in a short queue for the compute side.
// ----------------------------------------------------------------------------
module mm4_front
  import mm4_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  row_t  in_a,
  input  row_t  in_b,
  output logic  q_valid,
  input  logic  q_ready,
  output item_t q_item
);

  item_t              slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;
  idx_t               row_count;
  logic               push;
  logic               pop;

  assign in_ready = (count != (QPTR_W+1)'(QDEPTH));
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{a: in_a, b: in_b, row: row_count};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      row_count <= '0;
    end else begin
      if (push) begin
        wr_ptr    <= wr_ptr + 1'b1;
        row_count <= row_count + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/mm4_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_back
// Loads four queued rows into the A and B row registers, then computes the
// product row by row: four column lanes, one k term per cycle unless output
// stalls, product register and accumulator per lane, saturated into out_row.
// ----------------------------------------------------------------------------
module mm4_back
  import mm4_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  q_valid,
  output logic  q_ready,
  input  item_t q_item,
  output logic  out_valid,
  input  logic  out_ready,
  output row_t  out_row,
  output logic  last_row
);

  row_t  a_rows [DIM];
  row_t  b_rows [DIM];
  logic  loaded;
  idx_t  y;
  idx_t  k;

  // multiply stage
  prod_t prod [DIM];
  logic  m_valid;
  logic  m_first;
  logic  m_last;
  logic  m_lrow;

  acc_t  acc [DIM];
  acc_t  sum [DIM];
  elem_t a_sel;
  logic  en;
  logic  issue;
  logic  finish;

  assign q_ready = !loaded;
  assign finish  = en && m_valid && m_last;
  // a finished row may not overwrite an output nobody has taken yet
  assign en      = !(m_valid && m_last && out_valid && !out_ready);
  assign issue   = en && loaded;
  assign a_sel   = a_rows[y][k];

  always_comb begin
    for (int x = 0; x < DIM; x++) begin
      sum[x] = (m_first ? '0 : acc[x]) + ACC_W'(prod[x]);
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      a_rows[q_item.row] <= q_item.a;
      b_rows[q_item.row] <= q_item.b;
    end
  end

  always_ff @(posedge clk) begin
    elem_t b_sel;
    if (issue) begin
      for (int x = 0; x < DIM; x++) begin
        b_sel   = b_rows[k][x];
        prod[x] <= a_sel * b_sel;
      end
      m_first <= (k == '0);
      m_last  <= (k == LAST_IDX);
      m_lrow  <= (y == LAST_IDX);
    end
    if (en && m_valid && !m_last) begin
      for (int x = 0; x < DIM; x++) begin
        acc[x] <= sum[x];
      end
    end
    if (finish) begin
      for (int x = 0; x < DIM; x++) begin
        out_row[x] <= sat_shift(sum[x]);
      end
      last_row <= m_lrow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded    <= 1'b0;
      y         <= '0;
      k         <= '0;
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_valid && q_ready && (q_item.row == LAST_IDX)) begin
        loaded <= 1'b1;
        y      <= '0;
        k      <= '0;
      end else if (issue) begin
        k <= k + 1'b1;
        if (k == LAST_IDX) begin
          y <= y + 1'b1;
          if (y == LAST_IDX) begin
            loaded <= 1'b0;
          end
        end
      end
      if (en) begin
        m_valid <= issue;
      end
      priority if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/matrix4x4_multiply_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4x4_multiply_unit
// 4x4 signed Q16.16 matrix product C = A * B with saturated results.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): four transactions per matrix pair, each
// one row of A (a_elem0..3) and the row of B with the same index, rows 0..3.
// Output channel (out_valid/out_ready): after the fourth input, four
// transactions carry rows 0..3 of C; last_row marks row 3.
// Rows go into a four-entry queue, so the sender is not held up while a
// product is being computed. The compute side pops four rows (one a cycle),
// then runs four column lanes, one 32x32 multiply each, one k term a cycle
// while the output is not stalled. Each term passes through the product
// register into the accumulator, and the fourth term's sum is saturated
// into the output register; result rows come out in order 0..3.
// Each element is the exact sum of four products, floored by 2^16 and
// clamped to the 32-bit signed range.
// Reset (rst, synchronous) empties the queue, restarts the row count at row
// 0 and drops any product in flight. When out_ready is low the finished row
// holds in the output register and the lanes stall behind it; the queue
// keeps taking input rows until it is full.
// ----------------------------------------------------------------------------
module matrix4x4_multiply_unit
  import mm4_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  elem_t a_elem0,
  input  elem_t a_elem1,
  input  elem_t a_elem2,
  input  elem_t a_elem3,
  input  elem_t b_elem0,
  input  elem_t b_elem1,
  input  elem_t b_elem2,
  input  elem_t b_elem3,
  output logic  out_valid,
  input  logic  out_ready,
  output elem_t c_elem0,
  output elem_t c_elem1,
  output elem_t c_elem2,
  output elem_t c_elem3,
  output logic  last_row
);

  row_t  in_a;
  row_t  in_b;
  row_t  out_row;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  assign in_a = {a_elem3, a_elem2, a_elem1, a_elem0};
  assign in_b = {b_elem3, b_elem2, b_elem1, b_elem0};

  assign c_elem0 = out_row[0];
  assign c_elem1 = out_row[1];
  assign c_elem2 = out_row[2];
  assign c_elem3 = out_row[3];

  mm4_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_a     (in_a),
    .in_b     (in_b),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  mm4_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_row   (out_row),
    .last_row  (last_row)
  );

  // loading the last row of a pair switches the back end to computing
  a_load_done: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready && (q_item.row == LAST_IDX)) |=> !q_ready)
    else $error("back end still loading after last row");

  // an accepted input transaction is queued for the back end
  a_queued: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> q_valid)
    else $error("accepted row not visible in queue");

  // reset leaves no result pending and the queue open
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && in_ready && !q_valid))
    else $error("state not cleared by reset");

endmodule
